/* design/bfba_pkg.sv */
// Shared constants and types for the best-fit block allocator.
// Used by best_fit_block_allocator_core and its testbench; depends on nothing else.
`timescale 1ns / 1ps

package bfba_pkg;

  // Table geometry
  localparam int MAX_BLOCKS = 16;
  localparam int ADDR_W     = 16;
  localparam int ID_W       = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Stream payload widths
  localparam int IN_DATA_W  = ID_W + ADDR_W;
  localparam int OUT_DATA_W = 2 * ADDR_W;
  localparam int STAT_W     = 2;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_MEM_SIZE = 1'b0;
  localparam logic [ADDR_W-1:0] MEM_SIZE_RST = ADDR_W'(1024);

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // One table entry
  typedef struct packed {
    logic [ID_W-1:0]   blk_id;
    logic [ADDR_W-1:0] s_addr;
    logic [ADDR_W-1:0] e_addr;
  } entry_t;

endpackage

/* design/best_fit_block_allocator_core.sv */
// Best-fit block allocator: address-ordered block table in a small memory,
// walked by a sequencer around one shared gap subtract/compare unit.
// Depends on bfba_pkg.
`timescale 1ns / 1ps

// Allocate on a non-empty table: scan every entry for the smallest gap, move the entries
//   above it up one place, then write the new entry; allocate into an empty or a full
//   table, or free on an empty table, is answered without a table read.
// Free: scan for the first matching id, then move the entries after it down one place.
// in_tready returns in the cycle after the result is loaded into the output register.
// Reset (synchronous, rst_n low): entry count cleared, mem_size to 1024, table kept.
module best_fit_block_allocator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bfba_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bfba_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bfba_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bfba_pkg::IN_DATA_W-1:0]     in_tdata,   // block_id [15:0], req_size [31:16]
  input  logic [0:0]                         in_tuser,   // operation [0]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bfba_pkg::OUT_DATA_W-1:0]    out_tdata,  // start_addr [15:0], end_addr [31:16]
  output logic [bfba_pkg::STAT_W-1:0]        out_tuser   // status [1:0]
);

  localparam int ADDR_W = bfba_pkg::ADDR_W;
  localparam int ID_W   = bfba_pkg::ID_W;
  localparam int IDX_W  = bfba_pkg::IDX_W;
  localparam int CNT_W  = bfba_pkg::CNT_W;
  localparam int STAT_W = bfba_pkg::STAT_W;
  localparam int CFG_ADDR_W_IDX = bfba_pkg::CFG_ADDR_W - 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FIT   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  // Control registers
  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [ADDR_W-1:0]       mem_size_r, mem_size_nxt;
  logic                    rvld_r, rvld_nxt;
  logic                    found_r, found_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;

  // Payload registers
  logic                    op_r, op_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic [ADDR_W-1:0]       size_r, size_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        ridx_r, ridx_nxt;
  logic [IDX_W-1:0]        best_r, best_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [ADDR_W-1:0]       best_gap_r, best_gap_nxt;
  logic [ADDR_W-1:0]       best_end_r, best_end_nxt;
  logic [ADDR_W-1:0]       prev_end_r, prev_end_nxt;
  logic [STAT_W-1:0]       res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]       res_start_r, res_start_nxt;
  logic [ADDR_W-1:0]       res_end_r, res_end_nxt;
  logic [bfba_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [STAT_W-1:0]       out_tuser_r, out_tuser_nxt;

  // Entry table and its ports
  bfba_pkg::entry_t        mem_r [bfba_pkg::MAX_BLOCKS];
  bfba_pkg::entry_t        rdata_r;
  bfba_pkg::entry_t        wr_data;
  logic                    rd_en, wr_en;
  logic [IDX_W-1:0]        rd_addr, wr_addr;

  // Shared gap unit
  logic [ADDR_W-1:0]       ev_limit, ev_gap, place_end;
  logic [IDX_W-1:0]        ev_idx;
  logic                    ev_fit, scan_more, shift_more, id_hit, cfg_wr, cfg_sel;

  // Configuration access
  assign cfg_pready = 1'b1;
  assign cfg_sel    = (cfg_paddr[CFG_ADDR_W_IDX] == bfba_pkg::REG_MEM_SIZE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel;
  assign cfg_prdata = cfg_sel ? bfba_pkg::CFG_DATA_W'(mem_size_r) : '0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Gap after the previous entry: up to the entry just read, or to mem_size
  assign ev_limit  = rvld_r ? rdata_r.s_addr : mem_size_r;
  assign ev_gap    = ev_limit - prev_end_r;
  assign ev_fit    = (ev_limit >= prev_end_r) && (ev_gap >= size_r) &&
                     (!found_r || (ev_gap < best_gap_r));
  assign ev_idx    = rvld_r ? (ridx_r - 1'b1) : IDX_W'(count_r - 1'b1);
  assign place_end = best_end_r + size_r;

  assign scan_more  = (idx_r < count_r);
  assign shift_more = (op_r == bfba_pkg::OP_ALLOC) ? (idx_r >= CNT_W'(pos_r)) : scan_more;
  assign id_hit     = (rdata_r.blk_id == id_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    mem_size_nxt   = cfg_wr ? cfg_pwdata[ADDR_W-1:0] : mem_size_r;
    rvld_nxt       = 1'b0;
    found_nxt      = found_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    size_nxt       = size_r;
    idx_nxt        = idx_r;
    ridx_nxt       = ridx_r;
    best_nxt       = best_r;
    pos_nxt        = pos_r;
    best_gap_nxt   = best_gap_r;
    best_end_nxt   = best_end_r;
    prev_end_nxt   = prev_end_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_end_nxt    = res_end_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rd_en          = 1'b0;
    rd_addr        = idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = ridx_r;
    wr_data        = rdata_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = in_tuser[0];
          id_nxt         = in_tdata[ID_W-1:0];
          size_nxt       = in_tdata[ID_W +: ADDR_W];
          found_nxt      = 1'b0;
          idx_nxt        = CNT_W'(1);
          ridx_nxt       = '0;
          res_status_nxt = bfba_pkg::ST_OK;
          res_start_nxt  = '0;
          res_end_nxt    = '0;
          state_nxt      = S_RESP;
          if (in_tuser[0] == bfba_pkg::OP_ALLOC) begin
            if (count_r == CNT_W'(bfba_pkg::MAX_BLOCKS)) begin
              res_status_nxt = bfba_pkg::ST_FULL;
            end else if (count_r == '0) begin
              // empty table: place at zero if it fits
              if (in_tdata[ID_W +: ADDR_W] > mem_size_r) begin
                res_status_nxt = bfba_pkg::ST_NOFIT;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_data.blk_id = in_tdata[ID_W-1:0];
                wr_data.s_addr = '0;
                wr_data.e_addr = in_tdata[ID_W +: ADDR_W];
                count_nxt      = CNT_W'(1);
                res_end_nxt    = in_tdata[ID_W +: ADDR_W];
              end
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              rvld_nxt  = 1'b1;
              state_nxt = S_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = bfba_pkg::ST_NOTFOUND;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              rvld_nxt  = 1'b1;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // stream entries out of the table, one read a cycle
        if (scan_more) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          rvld_nxt = 1'b1;
          ridx_nxt = idx_r[IDX_W-1:0];
        end
        if (op_r == bfba_pkg::OP_ALLOC) begin
          if (rvld_r) begin
            prev_end_nxt = rdata_r.e_addr;
            if ((ridx_r != '0) && ev_fit) begin
              found_nxt    = 1'b1;
              best_nxt     = ev_idx;
              best_gap_nxt = ev_gap;
              best_end_nxt = prev_end_r;
            end
          end else begin
            // gap after the last entry runs to mem_size
            if (ev_fit) begin
              found_nxt    = 1'b1;
              best_nxt     = ev_idx;
              best_gap_nxt = ev_gap;
              best_end_nxt = prev_end_r;
            end
            state_nxt = S_FIT;
          end
        end else begin
          if (rvld_r && id_hit) begin
            // first match: drop the read in flight and close the hole
            res_start_nxt = rdata_r.s_addr;
            res_end_nxt   = rdata_r.e_addr;
            rd_en         = 1'b0;
            rvld_nxt      = 1'b0;
            idx_nxt       = CNT_W'(ridx_r) + 1'b1;
            state_nxt     = S_SHIFT;
          end else if (!rvld_r) begin
            res_status_nxt = bfba_pkg::ST_NOTFOUND;
            state_nxt      = S_RESP;
          end
        end
      end

      S_FIT: begin
        if (!found_r) begin
          res_status_nxt = bfba_pkg::ST_NOFIT;
          state_nxt      = S_RESP;
        end else begin
          pos_nxt   = best_r + 1'b1;
          idx_nxt   = count_r - 1'b1;
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // read one entry, write it one place over in the next cycle
        if (shift_more) begin
          rd_en    = 1'b1;
          rvld_nxt = 1'b1;
          ridx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = (op_r == bfba_pkg::OP_ALLOC) ? (idx_r - 1'b1) : (idx_r + 1'b1);
        end
        if (rvld_r) begin
          wr_en   = 1'b1;
          wr_addr = (op_r == bfba_pkg::OP_ALLOC) ? (ridx_r + 1'b1) : (ridx_r - 1'b1);
        end
        if (!shift_more && !rvld_r) begin
          if (op_r == bfba_pkg::OP_ALLOC) begin
            state_nxt = S_PLACE;
          end else begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_RESP;
          end
        end
      end

      S_PLACE: begin
        wr_en          = 1'b1;
        wr_addr        = pos_r;
        wr_data.blk_id = id_r;
        wr_data.s_addr = best_end_r;
        wr_data.e_addr = place_end;
        count_nxt      = count_r + 1'b1;
        res_start_nxt  = best_end_r;
        res_end_nxt    = place_end;
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {res_end_r, res_start_r};
          out_tuser_nxt  = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      mem_size_r   <= bfba_pkg::MEM_SIZE_RST;
      rvld_r       <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      mem_size_r   <= mem_size_nxt;
      rvld_r       <= rvld_nxt;
      found_r      <= found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    size_r       <= size_nxt;
    idx_r        <= idx_nxt;
    ridx_r       <= ridx_nxt;
    best_r       <= best_nxt;
    pos_r        <= pos_nxt;
    best_gap_r   <= best_gap_nxt;
    best_end_r   <= best_end_nxt;
    prev_end_r   <= prev_end_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_end_r    <= res_end_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  // Entry table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(bfba_pkg::MAX_BLOCKS))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == $past(count_r) + 1'b1) || (count_r == $past(count_r) - 1'b1)))
    else $error("entry count moved by more than one");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r != bfba_pkg::ST_OK)) |-> (out_tdata_r == '0))
    else $error("error result carries nonzero addresses");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("sequencer idle right after taking a request");

  a_shift_ports: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SHIFT) && wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("shift reads and writes the same entry");

endmodule

/* verif/tb_best_fit_block_allocator_core.sv */
// Self-checking testbench for best_fit_block_allocator_core: directed and random
// allocate/free requests, checked against an in-bench best-fit table predictor.
// Depends on bfba_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_best_fit_block_allocator_core;
  import bfba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] MEM_SIZE_ADDR = CFG_ADDR_W'(4 * int'(REG_MEM_SIZE));

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
  } blk_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // block_id [15:0], req_size [31:16]
  logic [0:0]            in_tuser    = '0;  // operation [0]
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // start_addr [15:0], end_addr [31:16]
  logic [STAT_W-1:0]     out_tuser;         // status [1:0]

  // Predicted allocator state
  entry_t            blk_tab [MAX_BLOCKS];
  int                blk_cnt   = 0;
  logic [ADDR_W-1:0] mem_units = MEM_SIZE_RST;

  blk_result_t pending_results [$];
  int          error_count = 0;
  bit          steady      = 1'b0;  // no idling on either side while set
  bit          valid_held  = 1'b0;  // mirrors the last value scheduled on in_tvalid

  best_fit_block_allocator_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #5 clk = ~clk;

  // Place a block in the smallest gap that holds it, earliest gap on ties
  function automatic blk_result_t place_block(logic [ID_W-1:0] id, logic [ADDR_W-1:0] size);
    blk_result_t       r;
    int                best;
    bit                found;
    logic [ADDR_W-1:0] limit;
    logic [ADDR_W-1:0] gap;
    logic [ADDR_W-1:0] best_gap;
    r        = '{ST_NOFIT, '0, '0};
    best     = 0;
    found    = 1'b0;
    best_gap = '0;
    if (blk_cnt == MAX_BLOCKS) begin
      r.status = ST_FULL;
      return r;
    end
    if (blk_cnt == 0) begin
      if (size > mem_units) return r;
      blk_tab[0] = '{id, '0, size};
      blk_cnt    = 1;
      return '{ST_OK, '0, size};
    end
    for (int i = 0; i < blk_cnt; i++) begin
      limit = (i + 1 < blk_cnt) ? blk_tab[i + 1].s_addr : mem_units;
      // skip a last block that lies past a shrunken memory
      if (limit >= blk_tab[i].e_addr) begin
        gap = limit - blk_tab[i].e_addr;
        if (gap >= size && (!found || gap < best_gap)) begin
          found    = 1'b1;
          best     = i;
          best_gap = gap;
        end
      end
    end
    if (!found) return r;
    r.status     = ST_OK;
    r.start_addr = blk_tab[best].e_addr;
    r.end_addr   = r.start_addr + size;
    for (int k = blk_cnt; k > best + 1; k--) blk_tab[k] = blk_tab[k - 1];
    blk_tab[best + 1] = '{id, r.start_addr, r.end_addr};
    blk_cnt++;
    return r;
  endfunction

  // Remove the lowest-addressed block with a matching id
  function automatic blk_result_t release_block(logic [ID_W-1:0] id);
    blk_result_t r;
    int          hit;
    r   = '{ST_NOTFOUND, '0, '0};
    hit = -1;
    for (int i = 0; i < blk_cnt; i++) begin
      if (hit < 0 && blk_tab[i].blk_id == id) hit = i;
    end
    if (hit < 0) return r;
    r = '{ST_OK, blk_tab[hit].s_addr, blk_tab[hit].e_addr};
    for (int k = hit; k + 1 < blk_cnt; k++) blk_tab[k] = blk_tab[k + 1];
    blk_cnt--;
    return r;
  endfunction

  // Send one request after a random gap, or none while steady; record its predicted result on acceptance
  task automatic send_request(logic op, logic [ID_W-1:0] id, logic [ADDR_W-1:0] size);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      if (valid_held) in_tvalid <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    valid_held = 1'b1;
    in_tdata   <= {size, id};
    in_tuser   <= op;
    do @(posedge clk); while (!in_tready);
    if (op == OP_ALLOC) pending_results.push_back(place_block(id, size));
    else pending_results.push_back(release_block(id));
  endtask

  // Hold off new requests until every predicted result has arrived
  task automatic wait_for_results();
    if (valid_held) in_tvalid <= 1'b0;
    valid_held = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write mem_size with a setup and an access cycle; only called while idle
  task automatic write_mem_size(logic [ADDR_W-1:0] units);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= MEM_SIZE_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(units);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    mem_units = units;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Empty table, zero size, exact fit, head free and the space before the head
  task automatic test_empty_table();
    send_request(OP_FREE, 16'h0000, 16'h0000);
    send_request(OP_ALLOC, 16'h0000, 16'h0000);
    send_request(OP_FREE, 16'h0000, 16'hFFFF);
    send_request(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    send_request(OP_ALLOC, 16'h0001, 16'd1024);
    send_request(OP_ALLOC, 16'h0002, 16'h0000);
    send_request(OP_FREE, 16'h0001, 16'h0000);
    send_request(OP_ALLOC, 16'h0003, 16'd10);
  endtask

  // Two blocks with one id: the free takes the lower one
  task automatic test_duplicate_ids();
    send_request(OP_FREE, 16'h0002, 16'h0000);
    send_request(OP_ALLOC, 16'h0007, 16'd100);
    send_request(OP_ALLOC, 16'h0007, 16'd100);
    send_request(OP_FREE, 16'h0007, 16'h0000);
  endtask

  // Fill every table entry, then one more allocate
  task automatic test_table_full();
    for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
      send_request(OP_ALLOC, ID_W'(16'h0100 + k), 16'd1);
    end
    send_request(OP_ALLOC, 16'h5A5A, 16'd1);
    wait_for_results();
  endtask

  // Random mix under one mem_size: mostly allocs from a small id pool and frees
  // of live ids, plus some noise with arbitrary fields
  task automatic random_phase(int n_items, logic [ADDR_W-1:0] units, int alloc_pct);
    int                roll;
    int                span;
    int                sz;
    logic              op;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   id_base;
    logic [ADDR_W-1:0] size;
    wait_for_results();
    write_mem_size(units);
    id_base = ID_W'($urandom);
    span    = int'(units) / 6 + 1;
    for (int k = 0; k < n_items; k++) begin
      steady = ((k / 40) % 5) == 2;
      roll   = $urandom_range(0, 99);
      if (roll < 8) begin
        op   = 1'($urandom_range(0, 1));
        id   = ID_W'($urandom);
        size = ADDR_W'($urandom);
      end else if (roll < alloc_pct) begin
        op = OP_ALLOC;
        id = $urandom_range(0, 3) == 0 ? ID_W'($urandom) :
                                         ID_W'(id_base + $urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0: sz = 0;
          1: sz = int'(units);
          2: sz = $urandom_range(0, int'(units) + 1);
          default: sz = $urandom_range(1, span);
        endcase
        size = ADDR_W'(sz);
      end else begin
        op   = OP_FREE;
        id   = blk_cnt > 0 ? blk_tab[$urandom_range(0, blk_cnt - 1)].blk_id : ID_W'($urandom);
        size = ADDR_W'($urandom);
      end
      send_request(op, id, size);
      if ($urandom_range(0, 199) == 0) wait_for_results();
    end
    steady = 1'b0;
  endtask

  // Accept results with random stalls, none while steady, and compare against the oldest prediction
  initial begin : result_checker
    blk_result_t want;
    int          stall;
    wait (rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d start %0d end %0d",
                 $time, out_tuser, out_tdata[15:0], out_tdata[31:16]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", ADDR_W'(want.status), ADDR_W'(out_tuser));
        check_field("start_addr", want.start_addr, out_tdata[15:0]);
        check_field("end_addr", want.end_addr, out_tdata[31:16]);
      end
    end
  end

  initial begin : run_tests
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_duplicate_ids();
    test_table_full();
    random_phase(380, 16'hFFFF, 60);
    random_phase(150, 16'd1, 45);
    random_phase(300, 16'd300, 55);
    random_phase(380, ADDR_W'($urandom_range(1, 65535)), 55);
    random_phase(380, 16'd64, 55);
    random_phase(280, MEM_SIZE_RST, 50);
    wait_for_results();
    // let any stray result show up before the verdict
    repeat (4 * MAX_BLOCKS + 20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* best_fit_block_allocator_core.f */
design/bfba_pkg.sv
design/best_fit_block_allocator_core.sv
verif/tb_best_fit_block_allocator_core.sv
